// ----- rtl/sasp_pkg.sv -----
// Shared types, codes and constants for the servo action sequence player.
package sasp_pkg;

  localparam int SASP_MAX_SERVOS = 8;

  // Depth of the result queue. One item makes at most two results.
  localparam int RQ_DEPTH = 4;
  localparam int RQ_AW    = $clog2(RQ_DEPTH);
  localparam int RQ_CW    = $clog2(RQ_DEPTH + 1);

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [7:0]  CHAIN_FROM_RST = 8'd100;
  localparam logic [7:0]  CHAIN_TO_RST   = 8'd101;
  localparam logic [31:0] CHAIN_REPS_RST = 32'd1;

  typedef enum logic [2:0] {
    CMD_START  = 3'd0,
    CMD_STOP   = 3'd1,
    CMD_TICK   = 3'd2,
    CMD_HEADER = 3'd3,
    CMD_SERVO  = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    KIND_FETCH = 2'd0,
    KIND_SERVO = 2'd1,
    KIND_DONE  = 2'd2,
    KIND_CHAIN = 2'd3
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CHAIN_FROM = 2'd0,
    CFG_CHAIN_TO   = 2'd1,
    CFG_CHAIN_REPS = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  group;
    logic [7:0]  frame;
    logic [7:0]  servo;
    logic [15:0] pos;
    logic [31:0] move_ms;
    logic        last;
  } res_t;

  localparam res_t RES_ZERO = '{kind: KIND_FETCH, group: 8'd0, frame: 8'd0, servo: 8'd0,
                                pos: 16'd0, move_ms: 32'd0, last: 1'b0};

endpackage

// ----- rtl/sasp_core.sv -----
// Playback state, configuration registers and per-transaction result generation.
module sasp_core #(
  parameter int MAX_SERVOS = sasp_pkg::SASP_MAX_SERVOS
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_take,
  input  logic [2:0]                     in_cmd,
  input  logic [31:0]                    in_now,
  input  logic [7:0]                     in_group,
  input  logic [31:0]                    in_repeat_times,
  input  logic [7:0]                     in_frame_total,
  input  logic [7:0]                     in_servo_count,
  input  logic [15:0]                    in_frame_time,
  input  logic [7:0]                     in_servo_id,
  input  logic [15:0]                    in_servo_pos,
  input  logic                           cfg_we,
  input  logic [sasp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sasp_pkg::CFG_DATA_W-1:0] cfg_data,
  output sasp_pkg::res_t                 res0,
  output sasp_pkg::res_t                 res1,
  output logic [1:0]                     res_cnt
);
  import sasp_pkg::*;

  localparam int SL_W = $clog2(MAX_SERVOS + 1);

  logic [7:0]      chain_from_r, chain_to_r;
  logic [31:0]     chain_reps_r;

  logic            running_r, running_nxt;
  logic            frame_done_r, frame_done_nxt;
  logic            awaiting_r, awaiting_nxt;
  logic [SL_W-1:0] servos_left_r, servos_left_nxt;
  logic [7:0]      cur_group_r, cur_group_nxt;
  logic [31:0]     repeat_total_r, repeat_total_nxt;
  logic [31:0]     repeats_done_r, repeats_done_nxt;
  logic [7:0]      frame_index_r, frame_index_nxt;
  logic [7:0]      frames_r, frames_nxt;
  logic [31:0]     deadline_r, deadline_nxt;
  logic [15:0]     move_time_r, move_time_nxt;

  logic [31:0]     elapsed;
  logic [7:0]      fi_inc;
  logic [31:0]     rd_inc;

  assign elapsed = in_now - deadline_r;
  assign fi_inc  = frame_index_r + 8'd1;
  assign rd_inc  = repeats_done_r + 32'd1;

  always_comb begin
    running_nxt      = running_r;
    frame_done_nxt   = frame_done_r;
    awaiting_nxt     = awaiting_r;
    servos_left_nxt  = servos_left_r;
    cur_group_nxt    = cur_group_r;
    repeat_total_nxt = repeat_total_r;
    repeats_done_nxt = repeats_done_r;
    frame_index_nxt  = frame_index_r;
    frames_nxt       = frames_r;
    deadline_nxt     = deadline_r;
    move_time_nxt    = move_time_r;
    res0             = RES_ZERO;
    res1             = RES_ZERO;
    res_cnt          = 2'd0;

    case (cmd_t'(in_cmd))
      CMD_START: begin
        if (in_frame_total != 8'd0) begin
          frames_nxt = in_frame_total;
          if (cur_group_r != in_group) begin
            // Group zero preempts whatever is playing.
            if (in_group == 8'd0) begin
              running_nxt     = 1'b0;
              repeats_done_nxt = 32'd0;
              frame_done_nxt  = 1'b1;
              awaiting_nxt    = 1'b0;
              servos_left_nxt = '0;
            end
          end else begin
            repeat_total_nxt = in_repeat_times;
          end
          if (!running_nxt) begin
            cur_group_nxt    = in_group;
            repeat_total_nxt = in_repeat_times;
            frame_index_nxt  = 8'd0;
            repeats_done_nxt = 32'd0;
            running_nxt      = 1'b1;
            deadline_nxt     = in_now;
          end
        end
      end
      CMD_STOP: begin
        running_nxt      = 1'b0;
        repeats_done_nxt = 32'd0;
        frame_done_nxt   = 1'b1;
        frame_index_nxt  = 8'd0;
        awaiting_nxt     = 1'b0;
        servos_left_nxt  = '0;
      end
      CMD_TICK: begin
        if (!running_r) begin
          frame_index_nxt  = 8'd0;
          repeats_done_nxt = 32'd0;
          frame_done_nxt   = 1'b1;
          deadline_nxt     = in_now;
        end else if (frame_done_r) begin
          frame_done_nxt = 1'b0;
          awaiting_nxt   = 1'b1;
          res0.kind      = KIND_FETCH;
          res0.group     = cur_group_r;
          res0.frame     = frame_index_r;
          res_cnt        = 2'd1;
        end else if (!awaiting_r && !elapsed[31]) begin
          // Deadline passed in wrapping time: move on to the next frame, or finish the repeat.
          frame_done_nxt = 1'b1;
          if (fi_inc >= frames_r) begin
            frame_index_nxt = 8'd0;
            if (repeat_total_r != 32'd0) begin
              repeats_done_nxt = rd_inc;
              if (rd_inc >= repeat_total_r) begin
                running_nxt = 1'b0;
                res0.kind   = KIND_DONE;
                res0.group  = cur_group_r;
                res_cnt     = 2'd1;
                if (cur_group_r == chain_from_r) begin
                  res1.kind    = KIND_CHAIN;
                  res1.group   = chain_to_r;
                  res1.move_ms = chain_reps_r;
                  res_cnt      = 2'd2;
                end
              end
            end
          end else begin
            frame_index_nxt = fi_inc;
          end
        end
      end
      CMD_HEADER: begin
        if (awaiting_r) begin
          awaiting_nxt = 1'b0;
          if (in_servo_count > 8'(MAX_SERVOS)) begin
            running_nxt      = 1'b0;
            repeats_done_nxt = 32'd0;
            frame_done_nxt   = 1'b1;
            frame_index_nxt  = 8'd0;
            servos_left_nxt  = '0;
          end else begin
            servos_left_nxt = in_servo_count[SL_W-1:0];
            move_time_nxt   = in_frame_time;
            deadline_nxt    = deadline_r + {16'd0, in_frame_time};
          end
        end
      end
      CMD_SERVO: begin
        if (servos_left_r != '0) begin
          servos_left_nxt = servos_left_r - SL_W'(1);
          res0.kind       = KIND_SERVO;
          res0.servo      = in_servo_id;
          res0.pos        = in_servo_pos;
          res0.move_ms    = {16'd0, move_time_r};
          res_cnt         = 2'd1;
        end
      end
      default: begin
      end
    endcase

    res0.last = (res_cnt == 2'd1);
    res1.last = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_r      <= 1'b0;
      frame_done_r   <= 1'b1;
      awaiting_r     <= 1'b0;
      servos_left_r  <= '0;
      cur_group_r    <= 8'd0;
      repeat_total_r <= 32'd1;
      repeats_done_r <= 32'd0;
      frame_index_r  <= 8'd0;
      frames_r       <= 8'd0;
      deadline_r     <= 32'd0;
      move_time_r    <= 16'd0;
    end else if (in_take) begin
      running_r      <= running_nxt;
      frame_done_r   <= frame_done_nxt;
      awaiting_r     <= awaiting_nxt;
      servos_left_r  <= servos_left_nxt;
      cur_group_r    <= cur_group_nxt;
      repeat_total_r <= repeat_total_nxt;
      repeats_done_r <= repeats_done_nxt;
      frame_index_r  <= frame_index_nxt;
      frames_r       <= frames_nxt;
      deadline_r     <= deadline_nxt;
      move_time_r    <= move_time_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chain_from_r <= CHAIN_FROM_RST;
      chain_to_r   <= CHAIN_TO_RST;
      chain_reps_r <= CHAIN_REPS_RST;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_CHAIN_FROM: chain_from_r <= cfg_data[7:0];
        CFG_CHAIN_TO:   chain_to_r   <= cfg_data[7:0];
        CFG_CHAIN_REPS: chain_reps_r <= cfg_data[31:0];
        default: begin
        end
      endcase
    end
  end

endmodule

// ----- rtl/sasp_rq.sv -----
// Result queue: takes up to two results a cycle and hands out one a cycle unless out_stall is high.
module sasp_rq (
  input  logic           clk,
  input  logic           rst_n,
  input  logic [1:0]     push_cnt,
  input  sasp_pkg::res_t push0,
  input  sasp_pkg::res_t push1,
  output logic           space2,
  output logic           out_valid,
  input  logic           out_stall,
  output sasp_pkg::res_t head
);
  import sasp_pkg::*;

  res_t             mem [RQ_DEPTH];
  logic [RQ_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [RQ_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [RQ_CW-1:0] count_r, count_nxt;
  logic             pop;
  logic [RQ_AW-1:0] wr_ptr_p1;

  assign out_valid = (count_r != '0);
  assign head      = mem[rd_ptr_r];
  assign space2    = (count_r <= RQ_CW'(RQ_DEPTH - 2));
  assign pop       = out_valid && !out_stall;
  assign wr_ptr_p1 = wr_ptr_r + RQ_AW'(1);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + RQ_AW'(push_cnt);
    rd_ptr_nxt = rd_ptr_r + RQ_AW'(pop);
    count_nxt  = count_r + RQ_CW'(push_cnt) - RQ_CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) begin
      mem[wr_ptr_r] <= push0;
    end
    if (push_cnt == 2'd2) begin
      mem[wr_ptr_p1] <= push1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// ----- rtl/servo_action_sequence_player.sv -----
// Top level of the servo action sequence player.
// The player takes one input transaction per cycle while in_stall is low and updates its
// playback state in the cycle the transaction is accepted; the results it causes (at most
// two: a done notice followed by a chain-start request) enter a four-entry result queue
// and appear on the output channel in order, one per cycle while out_stall is low.
// in_stall rises only when the queue has fewer than two free entries, so with a
// free-running output a stream of transactions is taken at one per cycle.
// Configuration writes take effect at the next edge and have no handshake.
module servo_action_sequence_player #(
  parameter int MAX_SERVOS = sasp_pkg::SASP_MAX_SERVOS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [2:0]                      in_cmd,
  input  logic [31:0]                     in_now,
  input  logic [7:0]                      in_group,
  input  logic [31:0]                     in_repeat_times,
  input  logic [7:0]                      in_frame_total,
  input  logic [7:0]                      in_servo_count,
  input  logic [15:0]                     in_frame_time,
  input  logic [7:0]                      in_servo_id,
  input  logic [15:0]                     in_servo_pos,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [1:0]                      out_kind,
  output logic [7:0]                      out_group,
  output logic [7:0]                      out_frame,
  output logic [7:0]                      out_servo,
  output logic [15:0]                     out_pos,
  output logic [31:0]                     out_time,
  output logic                            out_last,
  input  logic                            cfg_we,
  input  logic [sasp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sasp_pkg::CFG_DATA_W-1:0] cfg_data
);
  import sasp_pkg::*;

  logic       in_take;
  logic       space2;
  logic [1:0] res_cnt;
  logic [1:0] push_cnt;
  res_t       res0, res1, head;

  assign in_stall = !space2;
  assign in_take  = in_valid && space2;
  assign push_cnt = in_take ? res_cnt : 2'd0;

  sasp_core #(
    .MAX_SERVOS(MAX_SERVOS)
  ) u_core (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_take         (in_take),
    .in_cmd          (in_cmd),
    .in_now          (in_now),
    .in_group        (in_group),
    .in_repeat_times (in_repeat_times),
    .in_frame_total  (in_frame_total),
    .in_servo_count  (in_servo_count),
    .in_frame_time   (in_frame_time),
    .in_servo_id     (in_servo_id),
    .in_servo_pos    (in_servo_pos),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .res0            (res0),
    .res1            (res1),
    .res_cnt         (res_cnt)
  );

  sasp_rq u_rq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_cnt  (push_cnt),
    .push0     (res0),
    .push1     (res1),
    .space2    (space2),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .head      (head)
  );

  assign out_kind  = head.kind;
  assign out_group = head.group;
  assign out_frame = head.frame;
  assign out_servo = head.servo;
  assign out_pos   = head.pos;
  assign out_time  = head.move_ms;
  assign out_last  = head.last;

endmodule

// ----- rtl/sasp_checker.sv -----
// Port-level checks for the servo action sequence player, bound to the top level.
module sasp_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_stall,
  input logic [1:0] out_kind,
  input logic [7:0] out_group,
  input logic [7:0] out_frame,
  input logic       out_last
);
  import sasp_pkg::*;

  // A stalled result transaction stays offered.
  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result transaction dropped while stalled");

  // Reset empties the result queue.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result offered right after reset");

  // Servo commands carry no group or frame.
  a_servo_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == KIND_SERVO) |-> (out_group == 8'd0) && (out_frame == 8'd0))
    else $error("servo command with group or frame set");

  // A chain request always closes its transaction's results.
  a_chain_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == KIND_CHAIN) |-> out_last)
    else $error("chain request not marked last");

endmodule

bind servo_action_sequence_player sasp_checker u_sasp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_kind  (out_kind),
  .out_group (out_group),
  .out_frame (out_frame),
  .out_last  (out_last)
);
